FILE: design/tpvc_pkg.sv
// tpvc_pkg: shared types, constants and the transparency rule function of the
// two-plane video compositor. No dependencies; every other file uses it.

package tpvc_pkg;

   localparam int RGB_W    = 24;
   localparam int COMP_W   = 8;
   localparam int FACTOR_W = 6;
   localparam int CTRL_W   = 4;
   localparam int IDX_W    = 4;
   localparam int PROD_W   = 14;   // 239 * 63 fits in 14 bits
   localparam int RECIP_W  = 11;
   localparam int NUM_COMP = 3;

   localparam logic [COMP_W-1:0]  BLACK_LEVEL = 8'd16;
   localparam logic [PROD_W-1:0]  ICF_DIV     = 14'd63;
   // floor(2^16 / 63); the quotient estimate is exact or one short
   localparam logic [RECIP_W-1:0] ICF_RECIP   = 11'd1040;

   typedef enum logic [2:0] {
      RULE_ALWAYS   = 3'd0,
      RULE_KEY      = 3'd1,
      RULE_INVIS    = 3'd2,
      RULE_MF0      = 3'd3,
      RULE_MF1      = 3'd4,
      RULE_MF0_KEY  = 3'd5,
      RULE_MF1_KEY  = 3'd6,
      RULE_RESERVED = 3'd7
   } rule_type;

   typedef enum logic [IDX_W-1:0] {
      IDX_TRANSP_A = 4'd0,
      IDX_TRANSP_B = 4'd1,
      IDX_KEY_A    = 4'd2,
      IDX_KEY_B    = 4'd3,
      IDX_MASK_A   = 4'd4,
      IDX_MASK_B   = 4'd5,
      IDX_MIX      = 4'd6,
      IDX_B_FRONT  = 4'd7
   } csr_idx_type;

   typedef struct packed {
      logic [CTRL_W-1:0] transp_ctrl_a;
      logic [CTRL_W-1:0] transp_ctrl_b;
      logic [RGB_W-1:0]  key_color_a;
      logic [RGB_W-1:0]  key_color_b;
      logic [RGB_W-1:0]  key_mask_a;
      logic [RGB_W-1:0]  key_mask_b;
      logic              mix_enable;
      logic              b_in_front;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      transp_ctrl_a: 4'd8,
      transp_ctrl_b: 4'd8,
      key_color_a:   '0,
      key_color_b:   '0,
      key_mask_a:    '0,
      key_mask_b:    '0,
      mix_enable:    1'b0,
      b_in_front:    1'b0
   };

   // load enables of the three scaler stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } pipe_en_type;

   function automatic logic plane_transparent(
      input logic [CTRL_W-1:0] ctrl,
      input logic [RGB_W-1:0]  rgb,
      input logic              vis,
      input logic [RGB_W-1:0]  key,
      input logic [RGB_W-1:0]  mask,
      input logic              mf0,
      input logic              mf1
   );
      logic match;
      logic cond;
      logic result;
      match = ((rgb | mask) == (key | mask));
      cond  = 1'b0;
      result = 1'b0;
      case (rule_type'(ctrl[2:0]))
         RULE_ALWAYS:   cond = 1'b1;
         RULE_KEY:      cond = match;
         RULE_INVIS:    cond = !vis;
         RULE_MF0:      cond = mf0;
         RULE_MF1:      cond = mf1;
         RULE_MF0_KEY:  cond = mf0 || match;
         RULE_MF1_KEY:  cond = mf1 || match;
         default:       cond = 1'b0;
      endcase
      if (rule_type'(ctrl[2:0]) == RULE_RESERVED) begin
         result = 1'b0;
      end else begin
         result = ctrl[3] ? !cond : cond;
      end
      return result;
   endfunction

endpackage

FILE: design/tpvc_req_if.sv
// tpvc_req_if: input pixel channel of the compositor, valid/ready plus payload.
// Depends on tpvc_pkg for field widths.

interface tpvc_req_if;
   logic                               valid;
   logic                               ready;
   logic [tpvc_pkg::RGB_W-1:0]         pix_a_rgb;
   logic                               pix_a_visible;
   logic [tpvc_pkg::RGB_W-1:0]         pix_b_rgb;
   logic                               pix_b_visible;
   logic [tpvc_pkg::FACTOR_W-1:0]      factor_a;
   logic [tpvc_pkg::FACTOR_W-1:0]      factor_b;
   logic                               matte_flag_zero;
   logic                               matte_flag_one;
   logic [tpvc_pkg::RGB_W-1:0]         backdrop_rgb;

   modport source (
      output valid, pix_a_rgb, pix_a_visible, pix_b_rgb, pix_b_visible,
             factor_a, factor_b, matte_flag_zero, matte_flag_one, backdrop_rgb,
      input  ready
   );
   modport sink (
      input  valid, pix_a_rgb, pix_a_visible, pix_b_rgb, pix_b_visible,
             factor_a, factor_b, matte_flag_zero, matte_flag_one, backdrop_rgb,
      output ready
   );
endinterface

FILE: design/tpvc_rsp_if.sv
// tpvc_rsp_if: composed pixel channel of the compositor, valid/ready plus payload.
// Depends on tpvc_pkg for field widths.

interface tpvc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tpvc_pkg::RGB_W-1:0] screen_rgb;

   modport source (
      output valid, screen_rgb,
      input  ready
   );
   modport sink (
      input  valid, screen_rgb,
      output ready
   );
endinterface

FILE: design/tpvc_csr_if.sv
// tpvc_csr_if: register write channel of the compositor, index and data.
// Depends on tpvc_pkg for field widths.

interface tpvc_csr_if;
   logic                       valid;
   logic                       ready;
   logic [tpvc_pkg::IDX_W-1:0] index;
   logic [tpvc_pkg::RGB_W-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

FILE: design/tpvc_csr.sv
// tpvc_csr: configuration registers of the compositor, written over the csr channel.
// Depends on tpvc_pkg and tpvc_csr_if.

module tpvc_csr (
   input  logic              clock,
   input  logic              reset,
   tpvc_csr_if.sink          csr_if,
   output tpvc_pkg::cfg_type cfg
);

   tpvc_pkg::cfg_type cfg_ff;
   tpvc_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (tpvc_pkg::csr_idx_type'(csr_if.index))
            tpvc_pkg::IDX_TRANSP_A: cfg_in.transp_ctrl_a = csr_if.data[tpvc_pkg::CTRL_W-1:0];
            tpvc_pkg::IDX_TRANSP_B: cfg_in.transp_ctrl_b = csr_if.data[tpvc_pkg::CTRL_W-1:0];
            tpvc_pkg::IDX_KEY_A:    cfg_in.key_color_a   = csr_if.data;
            tpvc_pkg::IDX_KEY_B:    cfg_in.key_color_b   = csr_if.data;
            tpvc_pkg::IDX_MASK_A:   cfg_in.key_mask_a    = csr_if.data;
            tpvc_pkg::IDX_MASK_B:   cfg_in.key_mask_b    = csr_if.data;
            tpvc_pkg::IDX_MIX:      cfg_in.mix_enable    = csr_if.data[0];
            tpvc_pkg::IDX_B_FRONT:  cfg_in.b_in_front    = csr_if.data[0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tpvc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/tpvc_scale.sv
// tpvc_scale: three-stage scaler for one colour component, 16 + trunc(f*(c-16)/63).
// Depends on tpvc_pkg; stage enables come from the pipeline control in the top level.

module tpvc_scale (
   input  logic                               clock,
   input  tpvc_pkg::pipe_en_type              en,
   input  logic [tpvc_pkg::COMP_W-1:0]        comp,
   input  logic [tpvc_pkg::FACTOR_W-1:0]      factor,
   output logic [tpvc_pkg::COMP_W-1:0]        scaled
);

   localparam int CW = tpvc_pkg::COMP_W;
   localparam int PW = tpvc_pkg::PROD_W;
   localparam int RW = tpvc_pkg::RECIP_W;

   // stage 1: magnitude times factor
   logic signed [CW:0] diff;
   logic               neg_in;
   logic [CW-1:0]      mag;
   logic [PW-1:0]      prod_in;
   logic [PW-1:0]      prod1_ff;
   logic               neg1_ff;

   // stage 2: quotient estimate through reciprocal
   logic [PW+RW-1:0]   recip_prod;
   logic [CW-1:0]      q0_in;
   logic [CW-1:0]      q0_ff;
   logic [PW-1:0]      prod2_ff;
   logic               neg2_ff;

   // stage 3: one-step correction and black level
   logic [PW-1:0]      q63;
   logic [PW-1:0]      rem;
   logic [CW-1:0]      q;
   logic [CW-1:0]      scaled_in;
   logic [CW-1:0]      scaled_ff;

   always_comb begin
      diff    = $signed({1'b0, comp}) - $signed({1'b0, tpvc_pkg::BLACK_LEVEL});
      neg_in  = diff[CW];
      mag     = neg_in ? CW'(-diff) : diff[CW-1:0];
      prod_in = PW'(mag) * PW'(factor);
   end

   always_comb begin
      recip_prod = (PW+RW)'(prod1_ff) * (PW+RW)'(tpvc_pkg::ICF_RECIP);
      q0_in      = recip_prod[16 +: CW];
   end

   always_comb begin
      q63 = {q0_ff, 6'b0} - PW'(q0_ff);
      rem = prod2_ff - q63;
      q   = (rem >= tpvc_pkg::ICF_DIV) ? q0_ff + CW'(1) : q0_ff;
      // truncation toward zero: the magnitude quotient carries the sign
      scaled_in = neg2_ff ? tpvc_pkg::BLACK_LEVEL - q : tpvc_pkg::BLACK_LEVEL + q;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod1_ff <= prod_in;
         neg1_ff  <= neg_in;
      end
      if (en.s2) begin
         q0_ff    <= q0_in;
         prod2_ff <= prod1_ff;
         neg2_ff  <= neg1_ff;
      end
      if (en.s3) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

FILE: design/two_plane_video_compositor_top.sv
// Composes one screen pixel per input word from two video planes and a backdrop.
// Channels: req_if carries the two plane pixels with visibility bits, the two
// contribution factors, the matte flags and the backdrop colour; rsp_if returns
// the composed 24-bit RGB pixel; csr_if writes the eight configuration registers
// (index 0..7, other indexes ignored) and is always ready.
// Pipeline: a word accepted on req_if passes through the three scaler stages
// and then the compose/output register before its result shows on rsp_if.
// Throughput: one word per cycle while the receiver does not stall; every stage
// is one register deep and the slowest path is the 14x11 reciprocal multiply in
// the scaler's second stage.
// Reset clears all stage valid bits and loads the register reset values
// (transparency controls 8, everything else 0).
// When the receiver stalls, the output register holds its word and each stage
// holds only while the one after it is full, so up to four words are buffered
// before req_if.ready drops; nothing is lost or repeated.
// Depends on tpvc_pkg, the three channel interfaces, tpvc_csr and tpvc_scale.

module two_plane_video_compositor_top (
   input  logic        clock,
   input  logic        reset,
   tpvc_req_if.sink    req_if,
   tpvc_rsp_if.source  rsp_if,
   tpvc_csr_if.sink    csr_if
);

   localparam int CW = tpvc_pkg::COMP_W;
   localparam int NC = tpvc_pkg::NUM_COMP;

   tpvc_pkg::cfg_type     cfg;
   tpvc_pkg::pipe_en_type en;
   logic                  en4;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;

   logic ta_in, tb_in;
   logic s1_ta_ff, s1_tb_ff, s2_ta_ff, s2_tb_ff, s3_ta_ff, s3_tb_ff;
   logic [tpvc_pkg::RGB_W-1:0] s1_back_ff, s2_back_ff, s3_back_ff;

   logic [tpvc_pkg::RGB_W-1:0] sa, sb;
   logic [tpvc_pkg::RGB_W-1:0] pix_in;
   logic [tpvc_pkg::RGB_W-1:0] pix_ff;

   tpvc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // stall control, each stage loads when it is empty or the next one loads
   assign en4  = !s4_valid_ff || rsp_if.ready;
   assign en.s3 = !s3_valid_ff || en4;
   assign en.s2 = !s2_valid_ff || en.s3;
   assign en.s1 = !s1_valid_ff || en.s2;
   assign req_if.ready = en.s1;

   assign s1_valid_in = en.s1 ? req_if.valid : s1_valid_ff;
   assign s2_valid_in = en.s2 ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in = en.s3 ? s2_valid_ff  : s3_valid_ff;
   assign s4_valid_in = en4   ? s3_valid_ff  : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // key compare uses the unscaled plane pixel
   assign ta_in = tpvc_pkg::plane_transparent(cfg.transp_ctrl_a, req_if.pix_a_rgb,
                     req_if.pix_a_visible, cfg.key_color_a, cfg.key_mask_a,
                     req_if.matte_flag_zero, req_if.matte_flag_one);
   assign tb_in = tpvc_pkg::plane_transparent(cfg.transp_ctrl_b, req_if.pix_b_rgb,
                     req_if.pix_b_visible, cfg.key_color_b, cfg.key_mask_b,
                     req_if.matte_flag_zero, req_if.matte_flag_one);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s1_ta_ff   <= ta_in;
         s1_tb_ff   <= tb_in;
         s1_back_ff <= req_if.backdrop_rgb;
      end
      if (en.s2) begin
         s2_ta_ff   <= s1_ta_ff;
         s2_tb_ff   <= s1_tb_ff;
         s2_back_ff <= s1_back_ff;
      end
      if (en.s3) begin
         s3_ta_ff   <= s2_ta_ff;
         s3_tb_ff   <= s2_tb_ff;
         s3_back_ff <= s2_back_ff;
      end
   end

   for (genvar k = 0; k < NC; k++) begin : g_comp
      tpvc_scale u_scale_a (
         .clock  (clock),
         .en     (en),
         .comp   (req_if.pix_a_rgb[CW*k +: CW]),
         .factor (req_if.factor_a),
         .scaled (sa[CW*k +: CW])
      );
      tpvc_scale u_scale_b (
         .clock  (clock),
         .en     (en),
         .comp   (req_if.pix_b_rgb[CW*k +: CW]),
         .factor (req_if.factor_b),
         .scaled (sb[CW*k +: CW])
      );
   end

   // compose stage: overlay or mix, then the output register
   always_comb begin
      logic [tpvc_pkg::RGB_W-1:0] fp;
      logic [tpvc_pkg::RGB_W-1:0] bp;
      logic [tpvc_pkg::RGB_W-1:0] mixed;
      logic                       ft;
      logic                       bt;
      logic [CW:0]                sum;
      fp    = cfg.b_in_front ? sb : sa;
      bp    = cfg.b_in_front ? sa : sb;
      ft    = cfg.b_in_front ? s3_tb_ff : s3_ta_ff;
      bt    = cfg.b_in_front ? s3_ta_ff : s3_tb_ff;
      mixed = '0;
      sum   = '0;
      for (int k = 0; k < NC; k++) begin
         sum = {1'b0, fp[CW*k +: CW]} + {1'b0, bp[CW*k +: CW]};
         if (sum < {1'b0, tpvc_pkg::BLACK_LEVEL}) begin
            mixed[CW*k +: CW] = '0;
         end else if (sum[CW] && (sum[CW-1:0] >= tpvc_pkg::BLACK_LEVEL)) begin
            mixed[CW*k +: CW] = '1;
         end else begin
            mixed[CW*k +: CW] = CW'(sum - {1'b0, tpvc_pkg::BLACK_LEVEL});
         end
      end
      if (ft && bt) begin
         pix_in = s3_back_ff;
      end else if (ft) begin
         pix_in = bp;
      end else if (bt || !cfg.mix_enable) begin
         pix_in = fp;
      end else begin
         pix_in = mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         pix_ff <= pix_in;
      end
   end

   assign rsp_if.valid      = s4_valid_ff;
   assign rsp_if.screen_rgb = pix_ff;

`ifndef SYNTHESIS
   // a free receiver never backs up into the input
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_if.ready |-> req_if.ready)
      else $error("input stalled while output free");

   // a full third stage moves into the output register when it is enabled
   a_s3_to_out: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && en4) |=> s4_valid_ff)
      else $error("word lost between stage 3 and output");

   // both planes transparent shows the backdrop
   a_backdrop: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && en4 && s3_ta_ff && s3_tb_ff) |=>
         (rsp_if.screen_rgb == $past(s3_back_ff)))
      else $error("backdrop not shown for two transparent planes");

   // at most four words in flight
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && !rsp_if.ready)
         |-> !req_if.ready)
      else $error("input accepted with full pipeline");
`endif

endmodule
